// ===== rtl/core/rcm_pkg.sv =====
`default_nettype none
package rcm_pkg;

    localparam int Columns = 64;
    localparam int ColAw = (Columns > 1) ? $clog2(Columns) : 1;
    localparam int QDepth = 2;
    localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW = $clog2(QDepth + 1);
    localparam int DivBits = 54;
    localparam int DivCntW = $clog2(DivBits + 1);

    localparam logic OpInit = 1'b0;
    localparam logic OpUpdate = 1'b1;

    localparam logic [1:0] CfgRho = 2'd0;
    localparam logic [1:0] CfgDzt = 2'd1;
    localparam logic [1:0] CfgEps = 2'd2;
    localparam logic [1:0] CfgLimit = 2'd3;

    localparam logic [63:0] RhoReset = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] DztReset = 64'h3FD0_0000_0000_0000;
    localparam logic [63:0] EpsReset = 64'h3CB0_0000_0000_0000;
    localparam logic [7:0] LimitReset = 8'd10;

    localparam logic [1:0] XsWorking = 2'd0;
    localparam logic [1:0] XsNoProg = 2'd1;
    localparam logic [1:0] XsConv = 2'd2;
    localparam logic [1:0] XsReserved = 2'd3;
    localparam logic [1:0] ZsUnstable = 2'd0;
    localparam logic [1:0] ZsWorking = 2'd1;
    localparam logic [1:0] ZsNoProg = 2'd2;
    localparam logic [1:0] ZsConv = 2'd3;

    localparam logic [7:0] CntMax = 8'hFF;

    localparam logic [63:0] FpOne = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] FpPosInf = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] FpQNan = 64'h7FF8_0000_0000_0000;
    localparam logic [10:0] ExpMax = 11'h7FF;

    typedef enum logic [1:0] {
        K_INIT   = 2'd0,
        K_UPDATE = 2'd1,
        K_RANGE  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  column;
        logic [63:0] sol;
        logic [63:0] corr;
        logic [63:0] rel;
    } item_t;

    typedef struct packed {
        logic [1:0]  xs;
        logic [1:0]  zs;
        logic [63:0] pcorr;
        logic [63:0] prel;
        logic [7:0]  cnt;
        logic        fin;
    } entry_t;

    localparam int EntryW = $bits(entry_t);

    typedef struct packed {
        logic [63:0] rho;
        logic [63:0] dzt;
        logic [63:0] eps;
        logic [7:0]  limit;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic        zz_one;
        logic [63:0] a;
        logic [63:0] b;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [5:0] column;
        logic [1:0] xs;
        logic [1:0] zs;
        logic [7:0] iters;
        logic       fin;
    } result_t;

    function automatic logic fp_nan(input logic [63:0] a);
        return (a[62:52] == ExpMax) && (a[51:0] != '0);
    endfunction

    function automatic logic fp_zero(input logic [63:0] a);
        return a[62:0] == '0;
    endfunction

    function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
        logic r;
        if (fp_nan(a) || fp_nan(b) || (fp_zero(a) && fp_zero(b))) begin
            r = 1'b0;
        end else if (a[63] != b[63]) begin
            r = a[63];
        end else if (!a[63]) begin
            r = a[62:0] < b[62:0];
        end else begin
            r = a[62:0] > b[62:0];
        end
        return r;
    endfunction

    function automatic logic fp_le(input logic [63:0] a, input logic [63:0] b);
        return !fp_nan(a) && !fp_nan(b)
            && (fp_lt(a, b) || (a == b) || (fp_zero(a) && fp_zero(b)));
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rcm_ram.sv =====
`default_nettype none
module rcm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    wr_en,
    input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
    input  wire logic [Width-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
    output logic      [Width-1:0]                        rd_data
);
    logic [Width-1:0] mem_reg [Depth];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rcm_front.sv =====
`default_nettype none
module rcm_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_opcode,
    input  wire logic [5:0]        s_column,
    input  wire logic [63:0]       s_solution_norm,
    input  wire logic [63:0]       s_correction_norm,
    input  wire logic [63:0]       s_relative_correction_norm,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output rcm_pkg::item_t         q_item
);
    rcm_pkg::item_t                   slot_reg [rcm_pkg::QDepth];
    logic [rcm_pkg::QPtrW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [rcm_pkg::QCntW-1:0]        cnt_reg;
    rcm_pkg::item_t                   item_in;
    logic                             push, pop;

    always_comb begin
        item_in.column = s_column;
        item_in.sol = s_solution_norm;
        item_in.corr = s_correction_norm;
        item_in.rel = s_relative_correction_norm;
        if (32'(s_column) >= 32'(rcm_pkg::Columns)) begin
            item_in.kind = rcm_pkg::K_RANGE;
        end else if (s_opcode == rcm_pkg::OpUpdate) begin
            item_in.kind = rcm_pkg::K_UPDATE;
        end else begin
            item_in.kind = rcm_pkg::K_INIT;
        end
    end

    assign s_ready = (cnt_reg != rcm_pkg::QCntW'(rcm_pkg::QDepth));
    assign q_valid = (cnt_reg != '0);
    assign q_item = slot_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == rcm_pkg::QPtrW'(rcm_pkg::QDepth - 1))
                    ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == rcm_pkg::QPtrW'(rcm_pkg::QDepth - 1))
                    ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/rcm_fdiv.sv =====
`default_nettype none
module rcm_fdiv (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  rcm_pkg::div_req_t   req,
    output rcm_pkg::div_rsp_t   rsp
);
    typedef enum logic [5:0] {
        D_IDLE   = 6'b000001,
        D_NORM   = 6'b000010,
        D_DIV    = 6'b000100,
        D_DENORM = 6'b001000,
        D_ROUND  = 6'b010000,
        D_DONE   = 6'b100000
    } div_state_t;

    div_state_t                     state_reg, state_next;
    logic [52:0]                    ma_reg, mb_reg;
    logic signed [13:0]             ea_reg, eb_reg, exp_reg;
    logic [53:0]                    rem_reg, q_reg;
    logic                           st_reg, sign_reg;
    logic [63:0]                    res_reg;
    logic [rcm_pkg::DivCntW-1:0]    cnt_reg;

    logic [10:0]        xa, xb;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic               ge;
    logic [53:0]        diff, rem_next;
    logic signed [13:0] exp_base;
    logic [53:0]        mant54;
    logic [52:0]        mant;
    logic signed [13:0] exp_fin;

    always_comb begin
        xa = req.a[62:52];
        xb = req.b[62:52];
        a_nan = rcm_pkg::fp_nan(req.a);
        b_nan = rcm_pkg::fp_nan(req.b);
        a_inf = (xa == rcm_pkg::ExpMax) && (req.a[51:0] == '0);
        b_inf = (xb == rcm_pkg::ExpMax) && (req.b[51:0] == '0);
        a_zero = rcm_pkg::fp_zero(req.a);
        b_zero = rcm_pkg::fp_zero(req.b);
        sgn = req.a[63] ^ req.b[63];

        ge = rem_reg >= {1'b0, mb_reg};
        diff = ge ? rem_reg - {1'b0, mb_reg} : rem_reg;
        rem_next = {diff[52:0], 1'b0};
        exp_base = ea_reg - eb_reg + 14'sd1023;

        mant54 = {1'b0, q_reg[53:1]} + 54'(q_reg[0] && (st_reg || q_reg[1]));
        if (mant54[53]) begin
            mant = mant54[53:1];
            exp_fin = exp_reg + 14'sd1;
        end else begin
            mant = mant54[52:0];
            exp_fin = exp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // a new request is taken while idle or in the done cycle of the previous one
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE, D_DONE: begin
                if (req.start) begin
                    if ((req.a == rcm_pkg::FpPosInf && req.b == rcm_pkg::FpPosInf)
                        || a_nan || b_nan || b_zero || a_inf || b_inf || a_zero) begin
                        state_next = D_DONE;
                    end else begin
                        state_next = D_NORM;
                    end
                end else begin
                    state_next = D_IDLE;
                end
            end
            D_NORM:   if (ma_reg[52] && mb_reg[52]) state_next = D_DIV;
            D_DIV:    if (cnt_reg == rcm_pkg::DivCntW'(1)) state_next = D_DENORM;
            D_DENORM: if (exp_reg >= 14'sd1) state_next = D_ROUND;
            D_ROUND:  state_next = D_DONE;
            default:  state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            D_IDLE, D_DONE: begin
                // hold the last quotient until a new request starts
                if (req.start) begin
                    sign_reg <= sgn;
                    ma_reg <= {xa != '0, req.a[51:0]};
                    mb_reg <= {xb != '0, req.b[51:0]};
                    ea_reg <= (xa == '0) ? 14'sd1 : $signed({3'b000, xa});
                    eb_reg <= (xb == '0) ? 14'sd1 : $signed({3'b000, xb});
                    // special operands resolve here
                    if (req.a == rcm_pkg::FpPosInf && req.b == rcm_pkg::FpPosInf) begin
                        res_reg <= rcm_pkg::FpOne;
                    end else if (a_nan) begin
                        res_reg <= req.a;
                    end else if (b_nan) begin
                        res_reg <= req.b;
                    end else if (b_zero) begin
                        if (a_zero) begin
                            res_reg <= req.zz_one ? rcm_pkg::FpOne : '0;
                        end else begin
                            res_reg <= {sgn, rcm_pkg::FpPosInf[62:0]};
                        end
                    end else if (a_inf && b_inf) begin
                        res_reg <= rcm_pkg::FpQNan;
                    end else if (a_inf) begin
                        res_reg <= {sgn, rcm_pkg::FpPosInf[62:0]};
                    end else begin
                        res_reg <= {sgn, 63'd0};
                    end
                end
            end
            D_NORM: begin
                if (!ma_reg[52]) begin
                    ma_reg <= {ma_reg[51:0], 1'b0};
                    ea_reg <= ea_reg - 14'sd1;
                end
                if (!mb_reg[52]) begin
                    mb_reg <= {mb_reg[51:0], 1'b0};
                    eb_reg <= eb_reg - 14'sd1;
                end
                if (ma_reg[52] && mb_reg[52]) begin
                    q_reg <= '0;
                    cnt_reg <= rcm_pkg::DivCntW'(rcm_pkg::DivBits);
                    if (ma_reg < mb_reg) begin
                        rem_reg <= {ma_reg, 1'b0};
                        exp_reg <= exp_base - 14'sd1;
                    end else begin
                        rem_reg <= {1'b0, ma_reg};
                        exp_reg <= exp_base;
                    end
                end
            end
            D_DIV: begin
                q_reg <= {q_reg[52:0], ge};
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                st_reg <= rem_next != '0;
            end
            D_DENORM: begin
                // shift into the subnormal range, folding lost bits into sticky
                if (exp_reg < 14'sd1) begin
                    if (q_reg == '0) begin
                        exp_reg <= 14'sd1;
                    end else begin
                        q_reg <= {1'b0, q_reg[53:1]};
                        st_reg <= st_reg | q_reg[0];
                        exp_reg <= exp_reg + 14'sd1;
                    end
                end
            end
            D_ROUND: begin
                if (exp_fin >= 14'sd2047) begin
                    res_reg <= {sign_reg, rcm_pkg::FpPosInf[62:0]};
                end else begin
                    res_reg <= {sign_reg, mant[52] ? exp_fin[10:0] : 11'd0, mant[51:0]};
                end
            end
            default: ;
        endcase
    end

    assign rsp.done = (state_reg == D_DONE);
    assign rsp.quot = res_reg;
endmodule
`default_nettype wire

// ===== rtl/core/rcm_back.sv =====
`default_nettype none
module rcm_back (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     q_valid,
    output logic                          q_pop,
    input  rcm_pkg::item_t                q_item,
    input  rcm_pkg::cfg_t                 cfg,
    output logic                          rd_en,
    output logic [rcm_pkg::ColAw-1:0]     rd_addr,
    input  rcm_pkg::entry_t               rd_data,
    output logic                          wr_en,
    output logic [rcm_pkg::ColAw-1:0]     wr_addr,
    output rcm_pkg::entry_t               wr_data,
    output rcm_pkg::div_req_t             div_req,
    input  rcm_pkg::div_rsp_t             div_rsp,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output rcm_pkg::result_t              res
);
    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_LOAD = 7'b0000010,
        B_DIV1 = 7'b0000100,
        B_DIV2 = 7'b0001000,
        B_DIV3 = 7'b0010000,
        B_EVAL = 7'b0100000,
        B_OUT  = 7'b1000000
    } back_state_t;

    back_state_t       state_reg;
    rcm_pkg::item_t    item_reg;
    rcm_pkg::entry_t   entry_reg;
    logic [63:0]       prog_reg, prog2_reg;
    rcm_pkg::result_t  res_reg;
    logic              res_valid_reg;

    rcm_pkg::entry_t   init_entry, upd_entry;
    logic [1:0]        xs, zs;
    logic [7:0]        cnt_new;
    logic              out_free;

    assign out_free = !res_valid_reg || res_ready;
    assign q_pop = (state_reg == B_IDLE) && q_valid;
    assign rd_en = q_pop;
    assign rd_addr = rcm_pkg::ColAw'(q_item.column);
    assign wr_addr = rcm_pkg::ColAw'(item_reg.column);

    always_comb begin
        init_entry.xs = rcm_pkg::XsWorking;
        init_entry.zs = rcm_pkg::ZsUnstable;
        init_entry.pcorr = rcm_pkg::FpPosInf;
        init_entry.prel = rcm_pkg::FpPosInf;
        init_entry.cnt = '0;
        init_entry.fin = 1'b0;
    end

    // x and z state steps from the three ratios
    always_comb begin
        xs = entry_reg.xs;
        if (xs == rcm_pkg::XsNoProg && rcm_pkg::fp_le(prog_reg, cfg.rho)) begin
            xs = rcm_pkg::XsWorking;
        end
        if (xs == rcm_pkg::XsWorking) begin
            if (rcm_pkg::fp_le(prog2_reg, cfg.eps)) begin
                xs = rcm_pkg::XsConv;
            end else if (rcm_pkg::fp_lt(cfg.rho, prog_reg)) begin
                xs = rcm_pkg::XsNoProg;
            end
        end
        zs = entry_reg.zs;
        if (zs == rcm_pkg::ZsUnstable && rcm_pkg::fp_le(item_reg.rel, cfg.dzt)) begin
            zs = rcm_pkg::ZsWorking;
        end
        if (zs == rcm_pkg::ZsNoProg && rcm_pkg::fp_le(div_rsp.quot, cfg.rho)) begin
            zs = rcm_pkg::ZsWorking;
        end
        if (zs == rcm_pkg::ZsWorking) begin
            if (rcm_pkg::fp_le(item_reg.rel, cfg.eps)) begin
                zs = rcm_pkg::ZsConv;
            end else if (rcm_pkg::fp_lt(cfg.dzt, item_reg.rel)) begin
                zs = rcm_pkg::ZsUnstable;
            end else if (rcm_pkg::fp_lt(cfg.rho, div_rsp.quot)) begin
                zs = rcm_pkg::ZsNoProg;
            end
        end
        cnt_new = (entry_reg.cnt == rcm_pkg::CntMax) ? entry_reg.cnt : entry_reg.cnt + 8'd1;
        upd_entry.xs = xs;
        upd_entry.zs = zs;
        upd_entry.pcorr = item_reg.corr;
        upd_entry.prel = item_reg.rel;
        upd_entry.cnt = cnt_new;
        upd_entry.fin = !(xs == rcm_pkg::XsWorking || zs == rcm_pkg::ZsWorking)
            || (cnt_new >= cfg.limit);
    end

    always_comb begin
        wr_en = 1'b0;
        wr_data = init_entry;
        if (state_reg == B_LOAD && item_reg.kind == rcm_pkg::K_INIT) begin
            wr_en = 1'b1;
        end else if (state_reg == B_EVAL) begin
            wr_en = 1'b1;
            wr_data = upd_entry;
        end
    end

    always_comb begin
        div_req.start = 1'b0;
        div_req.zz_one = 1'b1;
        div_req.a = item_reg.corr;
        div_req.b = rd_data.pcorr;
        unique case (state_reg)
            B_LOAD: begin
                div_req.start = (item_reg.kind == rcm_pkg::K_UPDATE) && !rd_data.fin;
            end
            B_DIV1: begin
                div_req.start = div_rsp.done;
                div_req.zz_one = 1'b0;
                div_req.b = item_reg.sol;
            end
            B_DIV2: begin
                div_req.start = div_rsp.done;
                div_req.a = item_reg.rel;
                div_req.b = entry_reg.prel;
            end
            B_IDLE, B_DIV3, B_EVAL, B_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        case (state_reg)
            B_LOAD: entry_reg <= (item_reg.kind == rcm_pkg::K_INIT) ? init_entry : rd_data;
            B_DIV1: if (div_rsp.done) prog_reg <= div_rsp.quot;
            B_DIV2: if (div_rsp.done) prog2_reg <= div_rsp.quot;
            B_EVAL: entry_reg <= upd_entry;
            default: ;
        endcase
        if (state_reg == B_OUT && out_free) begin
            res_reg.column <= item_reg.column;
            if (item_reg.kind == rcm_pkg::K_RANGE) begin
                res_reg.xs <= '0;
                res_reg.zs <= '0;
                res_reg.iters <= '0;
                res_reg.fin <= 1'b0;
            end else begin
                res_reg.xs <= entry_reg.xs;
                res_reg.zs <= entry_reg.zs;
                res_reg.iters <= entry_reg.cnt;
                res_reg.fin <= entry_reg.fin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && res_ready) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: if (q_valid) state_reg <= B_LOAD;
                B_LOAD: begin
                    if (div_req.start) begin
                        state_reg <= B_DIV1;
                    end else begin
                        state_reg <= B_OUT;
                    end
                end
                B_DIV1: if (div_rsp.done) state_reg <= B_DIV2;
                B_DIV2: if (div_rsp.done) state_reg <= B_DIV3;
                // z ratio stays held in the divider and is read in the eval cycle
                B_DIV3: if (div_rsp.done) state_reg <= B_EVAL;
                B_EVAL: state_reg <= B_OUT;
                B_OUT: begin
                    if (out_free) begin
                        res_valid_reg <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;
endmodule
`default_nettype wire

// ===== rtl/core/refinement_convergence_monitor_core.sv =====
// Per-column convergence monitor for iterative refinement.
// Input channel (s_*): one beat per item. opcode init clears a column's state;
// opcode update carries the solution, correction and relative correction
// norms (IEEE doubles) and steps that column's x and z state machines.
// Result channel (m_*): exactly one beat per input beat, in order, giving
// the column's states, iteration count and finished flag after the item.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 rho limit, 1 relative step limit, 2 epsilon, 3 iteration limit).
// Init and finished-column items bypass the divider.
// An update runs three divisions through one shared bit-serial divider;
// special operands skip the iteration, others take one quotient bit per
// cycle, plus operand normalization and subnormal shifting.
// One item is worked at a time; a two-beat queue keeps taking input
// meanwhile, and the result register holds a beat while m_ready is low.
// Reset returns the registers to defaults and empties queue and result
// register; column state is undefined until an init item writes it.
`default_nettype none
module refinement_convergence_monitor_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [5:0]  s_column,
    input  wire logic [63:0] s_solution_norm,
    input  wire logic [63:0] s_correction_norm,
    input  wire logic [63:0] s_relative_correction_norm,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_column_out,
    output logic [1:0]       m_x_status,
    output logic [1:0]       m_z_status,
    output logic [7:0]       m_iterations_done,
    output logic             m_column_finished,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);
    rcm_pkg::cfg_t                cfg_reg;
    logic                         q_valid, q_pop;
    rcm_pkg::item_t               q_item;
    logic                         rd_en, wr_en;
    logic [rcm_pkg::ColAw-1:0]    rd_addr, wr_addr;
    rcm_pkg::entry_t              rd_data, wr_data;
    rcm_pkg::div_req_t            div_req;
    rcm_pkg::div_rsp_t            div_rsp;
    rcm_pkg::result_t             res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rho <= rcm_pkg::RhoReset;
            cfg_reg.dzt <= rcm_pkg::DztReset;
            cfg_reg.eps <= rcm_pkg::EpsReset;
            cfg_reg.limit <= rcm_pkg::LimitReset;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rcm_pkg::CfgRho:   cfg_reg.rho <= cfg_wdata;
                rcm_pkg::CfgDzt:   cfg_reg.dzt <= cfg_wdata;
                rcm_pkg::CfgEps:   cfg_reg.eps <= cfg_wdata;
                rcm_pkg::CfgLimit: cfg_reg.limit <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    rcm_front u_front (
        .aclk                       (aclk),
        .aresetn                    (aresetn),
        .s_valid                    (s_valid),
        .s_ready                    (s_ready),
        .s_opcode                   (s_opcode),
        .s_column                   (s_column),
        .s_solution_norm            (s_solution_norm),
        .s_correction_norm          (s_correction_norm),
        .s_relative_correction_norm (s_relative_correction_norm),
        .q_valid                    (q_valid),
        .q_pop                      (q_pop),
        .q_item                     (q_item)
    );

    rcm_ram #(
        .Width (rcm_pkg::EntryW),
        .Depth (rcm_pkg::Columns)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rcm_fdiv u_fdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    rcm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .cfg       (cfg_reg),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_column_out = res.column;
    assign m_x_status = res.xs;
    assign m_z_status = res.zs;
    assign m_iterations_done = res.iters;
    assign m_column_finished = res.fin;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset left a result or a full queue");

    a_x_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_x_status != rcm_pkg::XsReserved)
        else $error("x status carries an unused code");

    a_fresh_column: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_iterations_done == 8'd0 && m_column_finished
        |-> cfg_reg.limit == 8'd0)
        else $error("column finished without any counted iteration");
`endif
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
    import rcm_pkg::*;

    typedef struct {
        logic        op;
        logic [5:0]  col;
        logic [63:0] sol;
        logic [63:0] corr;
        logic [63:0] rel;
    } norm_beat_t;

    localparam logic [63:0] PosInf = 64'h7FF0_0000_0000_0000;
    localparam int StallLimit = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic        s_opcode = OpInit;
    logic [5:0]  s_column = '0;
    logic [63:0] s_solution_norm = '0;
    logic [63:0] s_correction_norm = '0;
    logic [63:0] s_relative_correction_norm = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [5:0]  m_column_out;
    wire  [1:0]  m_x_status;
    wire  [1:0]  m_z_status;
    wire  [7:0]  m_iterations_done;
    wire         m_column_finished;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CfgRho;
    logic [63:0] cfg_wdata = '0;

    refinement_convergence_monitor_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_column(s_column), .s_solution_norm(s_solution_norm),
        .s_correction_norm(s_correction_norm),
        .s_relative_correction_norm(s_relative_correction_norm),
        .m_valid(m_valid), .m_ready(m_ready), .m_column_out(m_column_out),
        .m_x_status(m_x_status), .m_z_status(m_z_status),
        .m_iterations_done(m_iterations_done),
        .m_column_finished(m_column_finished),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    norm_beat_t pending_beats[$];
    result_t    expected_status[$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         send_hold = 1'b0;
    bit         long_stall_req = 1'b0;
    bit         long_stall_ack = 1'b0;
    int         stall_cycles = 0;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    // configuration as seen by the predictor
    logic [63:0] rho_bits = RhoReset;
    logic [63:0] dzt_bits = DztReset;
    logic [63:0] eps_bits = EpsReset;
    logic [7:0]  iter_limit = LimitReset;

    // per-column tracking state
    logic [1:0]  col_xs[64];
    logic [1:0]  col_zs[64];
    logic [63:0] col_prev_corr[64];
    logic [63:0] col_prev_rel[64];
    logic [7:0]  col_count[64];
    logic        col_fin[64];

    // generator state
    bit gen_live[64];
    int gen_cexp[64];
    int gen_rexp[64];

    function automatic bit is_nan_bits(input logic [63:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != '0);
    endfunction

    // quotient with 1 for inf/inf and a chosen value for 0/0
    function automatic real norm_quotient(input logic [63:0] a, input logic [63:0] b,
                                          input real zero_zero);
        real ra;
        real rb;
        ra = $bitstoreal(a);
        rb = $bitstoreal(b);
        if (a == PosInf && b == PosInf) return 1.0;
        if (is_nan_bits(a)) return ra;
        if (is_nan_bits(b)) return rb;
        if (rb == 0.0) begin
            if (ra == 0.0) return zero_zero;
            return $bitstoreal({a[63] ^ b[63], PosInf[62:0]});
        end
        return ra / rb;
    endfunction

    function automatic result_t predict_status(input norm_beat_t bt);
        result_t r;
        int c;
        logic [1:0] xs;
        logic [1:0] zs;
        real rho;
        real dzt;
        real eps;
        real prog;
        real prog2;
        real zprog;
        real dz;
        c = bt.col;
        if (bt.op == OpInit) begin
            col_xs[c] = XsWorking;
            col_zs[c] = ZsUnstable;
            col_prev_corr[c] = PosInf;
            col_prev_rel[c] = PosInf;
            col_count[c] = '0;
            col_fin[c] = 1'b0;
        end else if (!col_fin[c]) begin
            rho = $bitstoreal(rho_bits);
            dzt = $bitstoreal(dzt_bits);
            eps = $bitstoreal(eps_bits);
            xs = col_xs[c];
            prog = norm_quotient(bt.corr, col_prev_corr[c], 1.0);
            prog2 = norm_quotient(bt.corr, bt.sol, 0.0);
            if (xs == XsNoProg && prog <= rho) xs = XsWorking;
            if (xs == XsWorking) begin
                if (prog2 <= eps) xs = XsConv;
                else if (prog > rho) xs = XsNoProg;
            end
            zs = col_zs[c];
            dz = $bitstoreal(bt.rel);
            zprog = norm_quotient(bt.rel, col_prev_rel[c], 1.0);
            if (zs == ZsUnstable && dz <= dzt) zs = ZsWorking;
            if (zs == ZsNoProg && zprog <= rho) zs = ZsWorking;
            if (zs == ZsWorking) begin
                if (dz <= eps) zs = ZsConv;
                else if (dz > dzt) zs = ZsUnstable;
                else if (zprog > rho) zs = ZsNoProg;
            end
            col_xs[c] = xs;
            col_zs[c] = zs;
            col_prev_corr[c] = bt.corr;
            col_prev_rel[c] = bt.rel;
            if (col_count[c] != CntMax) col_count[c] = col_count[c] + 8'd1;
            if (!(xs == XsWorking || zs == ZsWorking)) col_fin[c] = 1'b1;
            else if (col_count[c] >= iter_limit) col_fin[c] = 1'b1;
        end
        r.column = bt.col;
        r.xs = col_xs[c];
        r.zs = col_zs[c];
        r.iters = col_count[c];
        r.fin = col_fin[c];
        return r;
    endfunction

    // driver: advance to the next beat once the current one is taken
    always @(posedge aclk) begin
        norm_beat_t nb;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                nb.op = s_opcode;
                nb.col = s_column;
                nb.sol = s_solution_norm;
                nb.corr = s_correction_norm;
                nb.rel = s_relative_correction_norm;
                expected_status.push_back(predict_status(nb));
            end
            if (pending_beats.size() > 0 && !send_hold
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                nb = pending_beats.pop_front();
                s_valid <= 1'b1;
                s_opcode <= nb.op;
                s_column <= nb.col;
                s_solution_norm <= nb.sol;
                s_correction_norm <= nb.corr;
                s_relative_correction_norm <= nb.rel;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result beat against the oldest prediction
    always @(posedge aclk) begin
        result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    $error("result beat with no prediction pending, column %0d", m_column_out);
                    mismatch_count++;
                end else begin
                    e = expected_status.pop_front();
                    if (m_column_out !== e.column) begin
                        $error("column_out exp %0d got %0d", e.column, m_column_out);
                        mismatch_count++;
                    end
                    if (m_x_status !== e.xs) begin
                        $error("x_status exp %0d got %0d", e.xs, m_x_status);
                        mismatch_count++;
                    end
                    if (m_z_status !== e.zs) begin
                        $error("z_status exp %0d got %0d", e.zs, m_z_status);
                        mismatch_count++;
                    end
                    if (m_iterations_done !== e.iters) begin
                        $error("iterations_done exp %0d got %0d", e.iters, m_iterations_done);
                        mismatch_count++;
                    end
                    if (m_column_finished !== e.fin) begin
                        $error("column_finished exp %0d got %0d", e.fin, m_column_finished);
                        mismatch_count++;
                    end
                end
            end
            if (long_stall_req != long_stall_ack) begin
                long_stall_ack = long_stall_req;
                stall_cycles = 3000;
            end
            if (stall_cycles > 0) begin
                stall_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] fp_with_exp(input int e);
        logic [63:0] m;
        m = {$urandom, $urandom};
        return {1'b0, e[10:0], m[51:0]};
    endfunction

    function automatic logic [63:0] odd_fp();
        logic [63:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return 64'h8000_0000_0000_0000;
            2: return PosInf;
            3: return {1'b1, PosInf[62:0]};
            4: return {m[63], 11'h7FF, m[51:1], 1'b1};
            5: return {m[63], 11'h0, m[51:0]};
            6: return m;
            default: return FpOne;
        endcase
    endfunction

    task automatic push_beat(input logic op, input int col, input logic [63:0] sol,
                             input logic [63:0] corr, input logic [63:0] rel);
        norm_beat_t nb;
        nb.op = op;
        nb.col = col[5:0];
        nb.sol = sol;
        nb.corr = corr;
        nb.rel = rel;
        pending_beats.push_back(nb);
        if (op == OpInit) begin
            gen_live[col] = 1'b1;
            gen_cexp[col] = $urandom_range(990, 1030);
            gen_rexp[col] = $urandom_range(1016, 1024);
        end
    endtask

    task automatic push_random(input int count);
        int col;
        int k;
        for (k = 0; k < count; k++) begin
            col = $urandom_range(0, 63);
            if (!gen_live[col] || $urandom_range(0, 99) < 8) begin
                push_beat(OpInit, col, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom});
            end else if ($urandom_range(0, 99) < 75) begin
                // plausible refinement step: norms mostly shrink, sometimes stall or grow
                gen_cexp[col] -= $urandom_range(0, 99) < 20 ? -1 : $urandom_range(0, 12);
                gen_rexp[col] -= $urandom_range(0, 99) < 20 ? -1 : $urandom_range(0, 12);
                if (gen_cexp[col] < 1) gen_cexp[col] = 1;
                if (gen_rexp[col] < 1) gen_rexp[col] = 1;
                push_beat(OpUpdate, col, fp_with_exp($urandom_range(1020, 1026)),
                          fp_with_exp(gen_cexp[col]), fp_with_exp(gen_rexp[col]));
            end else begin
                push_beat(OpUpdate, col,
                          $urandom_range(0, 1) ? odd_fp() : {$urandom, $urandom},
                          $urandom_range(0, 1) ? odd_fp() : {$urandom, $urandom},
                          $urandom_range(0, 1) ? odd_fp() : {$urandom, $urandom});
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || s_valid || expected_status.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CfgRho: rho_bits = val;
            CfgDzt: dzt_bits = val;
            CfgEps: eps_bits = val;
            default: iter_limit = val[7:0];
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [63:0] rho, input logic [63:0] dzt,
                              input logic [63:0] eps, input logic [7:0] lim);
        write_reg(CfgRho, rho);
        write_reg(CfgDzt, dzt);
        write_reg(CfgEps, eps);
        write_reg(CfgLimit, {56'h0, lim});
    endtask

    initial begin
        int ph;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 18;
        recv_idle_pct = 57;

        // directed: zero, infinite, NaN, negative, subnormal, finished columns
        push_beat(OpInit, 0, 0, 0, 0);
        push_beat(OpInit, 63, 0, 0, 0);
        push_beat(OpUpdate, 0, 64'h0, 64'h0, 64'h0);
        push_beat(OpUpdate, 0, 64'h0, 64'h0, 64'h0);
        push_beat(OpUpdate, 63, PosInf, PosInf, PosInf);
        push_beat(OpUpdate, 63, FpOne, 64'h7FF8_0000_0000_0001, 64'hFFF8_0000_0000_0000);
        push_beat(OpUpdate, 63, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                  64'h3FD0_0000_0000_0000);
        push_beat(OpInit, 5, '1, '1, '1);
        push_beat(OpUpdate, 5, 64'h0, FpOne, 64'h3FC0_0000_0000_0000);
        push_beat(OpUpdate, 5, FpOne, 64'h3FE8_0000_0000_0000, 64'h3FC0_0000_0000_0000);
        push_beat(OpUpdate, 5, FpOne, 64'h0000_0000_0000_0001, 64'h0);
        push_beat(OpUpdate, 5, FpOne, FpOne, FpOne);
        push_beat(OpUpdate, 0, {1'b1, PosInf[62:0]}, 64'hBFF0_0000_0000_0000,
                  64'hFFFF_FFFF_FFFF_FFFF);
        push_beat(OpInit, 1, 0, 0, 0);
        for (int i = 0; i < 11; i++)
            push_beat(OpUpdate, 1, FpOne, FpOne, 64'h3FC0_0000_0000_0000);
        push_random(250);
        wait_drained();
        // sender pause until everything is back, then a long receiver hold-off
        push_random(150);
        long_stall_req = ~long_stall_req;
        wait_drained();

        for (ph = 1; ph <= 4; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 57;
                recv_idle_pct = 18;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1: set_config(64'h3FEC_CCCC_CCCC_CCCD, 64'h3FE0_0000_0000_0000,
                              64'h3E10_0000_0000_0000, 8'd255);
                2: set_config(64'h0, '1, 64'h0, 8'd0);
                3: set_config('1, PosInf, PosInf, 8'd1);
                default: set_config(RhoReset, DztReset, EpsReset, LimitReset);
            endcase
            push_random(400);
            wait_drained();
        end

        if (mismatch_count == 0 && expected_status.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
